FILE: design/cdq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Operation and status codes, the result record handed from the control
// unit to the output stage, and the default ring depth.
// ---------------------------------------------------------------------------
package cdq_pkg;

   localparam int CDQ_DEPTH_DEFAULT = 8;
   localparam int CDQ_WORD_W        = 32;
   localparam int CDQ_OCC_W         = 4;

   typedef enum logic [1:0] {
      CDQ_PUSH_FRONT = 2'd0,
      CDQ_PUSH_BACK  = 2'd1,
      CDQ_POP_FRONT  = 2'd2,
      CDQ_POP_BACK   = 2'd3
   } cdq_kind_type;

   typedef enum logic [1:0] {
      CDQ_ST_DONE      = 2'd0,
      CDQ_ST_OVERFLOW  = 2'd1,
      CDQ_ST_UNDERFLOW = 2'd2
   } cdq_status_type;

   typedef enum logic {
      CDQ_IDLE = 1'b0,
      CDQ_EXEC = 1'b1
   } cdq_state_type;

   typedef struct packed {
      logic signed [CDQ_WORD_W-1:0] popped;
      logic signed [CDQ_WORD_W-1:0] front_word;
      logic signed [CDQ_WORD_W-1:0] rear_word;
      logic [CDQ_OCC_W-1:0]         occupancy;
      logic                         empty_res;
      logic                         full_res;
      cdq_status_type               status;
   } cdq_result_type;

endpackage
`default_nettype wire

FILE: design/cdq_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_ram: ring store of the deque
// One write port and one read port; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
module cdq_ram
   import cdq_pkg::*;
#(
   parameter int DEPTH = CDQ_DEPTH_DEFAULT,
   parameter int AW    = $clog2(CDQ_DEPTH_DEFAULT)
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [AW-1:0]                wr_addr,
   input  wire logic signed [CDQ_WORD_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [AW-1:0]                rd_addr,
   output logic signed [CDQ_WORD_W-1:0]      rd_data
);

   logic signed [CDQ_WORD_W-1:0] store_ff [DEPTH];
   logic signed [CDQ_WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/cdq_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_ctrl: pointer and peek control of the deque
// Keeps head, tail and count, caches the front and rear words, drives the
// ring store and assembles one result per item.
// ---------------------------------------------------------------------------
module cdq_ctrl
   import cdq_pkg::*;
#(
   parameter int DEPTH = CDQ_DEPTH_DEFAULT,
   parameter int AW    = $clog2(CDQ_DEPTH_DEFAULT),
   parameter int CW    = $clog2(CDQ_DEPTH_DEFAULT + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [1:0]                   req_kind,
   input  wire logic signed [CDQ_WORD_W-1:0] req_value,
   output logic                              req_stall,
   input  wire logic                         out_free,
   output logic                              done,
   output cdq_result_type                    result,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic signed [CDQ_WORD_W-1:0]      wr_data,
   output logic                              rd_en,
   output logic [AW-1:0]                     rd_addr,
   input  wire logic signed [CDQ_WORD_W-1:0] rd_data
);

   cdq_state_type state_ff, state_in;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [CDQ_WORD_W-1:0] front_ff, front_in;
   logic signed [CDQ_WORD_W-1:0] rear_ff, rear_in;
   logic signed [CDQ_WORD_W-1:0] popped_ff, popped_in;
   cdq_status_type status_ff, status_in;
   logic fix_front_ff, fix_front_in;
   logic fix_rear_ff, fix_rear_in;

   logic accept;
   logic is_empty, is_full, is_single;
   logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
   cdq_kind_type kind;

   assign kind      = cdq_kind_type'(req_kind);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_single = (count_ff == CW'(1));

   // Ring positions step modulo DEPTH, which need not be a power of two.
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign tail_inc = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   assign tail_dec = (tail_ff == '0) ? AW'(DEPTH - 1) : tail_ff - AW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CDQ_IDLE: begin
            if (req_valid) begin
               state_in = CDQ_EXEC;
            end
         end
         CDQ_EXEC: begin
            if (out_free) begin
               state_in = CDQ_IDLE;
            end
         end
         default: state_in = CDQ_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         CDQ_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         CDQ_EXEC: begin
            done = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      fix_front_in = fix_front_ff;
      fix_rear_in  = fix_rear_ff;
      wr_en        = 1'b0;
      wr_addr      = head_dec;
      wr_data      = req_value;
      rd_en        = 1'b0;
      rd_addr      = head_inc;

      if (accept) begin
         popped_in    = '0;
         status_in    = CDQ_ST_DONE;
         fix_front_in = 1'b0;
         fix_rear_in  = 1'b0;
         unique case (kind)
            CDQ_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = CDQ_ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  front_in = req_value;
                  if (is_empty) begin
                     rear_in = req_value;
                  end
               end
            end
            CDQ_PUSH_BACK: begin
               if (is_full) begin
                  status_in = CDQ_ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_inc;
                  tail_in  = tail_inc;
                  count_in = count_ff + CW'(1);
                  rear_in  = req_value;
                  if (is_empty) begin
                     front_in = req_value;
                  end
               end
            end
            CDQ_POP_FRONT: begin
               if (is_empty) begin
                  status_in = CDQ_ST_UNDERFLOW;
               end else begin
                  popped_in = front_ff;
                  head_in   = head_inc;
                  count_in  = count_ff - CW'(1);
                  if (is_single) begin
                     front_in = '0;
                     rear_in  = '0;
                  end else begin
                     // The next front word arrives from the store in the following cycle.
                     rd_en        = 1'b1;
                     rd_addr      = head_inc;
                     fix_front_in = 1'b1;
                  end
               end
            end
            CDQ_POP_BACK: begin
               if (is_empty) begin
                  status_in = CDQ_ST_UNDERFLOW;
               end else begin
                  popped_in = rear_ff;
                  tail_in   = tail_dec;
                  count_in  = count_ff - CW'(1);
                  if (is_single) begin
                     front_in = '0;
                     rear_in  = '0;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = tail_dec;
                     fix_rear_in = 1'b1;
                  end
               end
            end
            default: status_in = CDQ_ST_DONE;
         endcase
      end

      if (done) begin
         if (fix_front_ff) begin
            front_in = rd_data;
         end
         if (fix_rear_ff) begin
            rear_in = rd_data;
         end
         fix_front_in = 1'b0;
         fix_rear_in  = 1'b0;
      end
   end

   always_comb begin
      result.popped     = popped_ff;
      result.front_word = fix_front_ff ? rd_data : front_ff;
      result.rear_word  = fix_rear_ff ? rd_data : rear_ff;
      result.occupancy  = CDQ_OCC_W'(count_ff);
      result.empty_res  = is_empty;
      result.full_res   = is_full;
      result.status     = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CDQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= AW'(DEPTH - 1);
         count_ff     <= '0;
         front_ff     <= '0;
         rear_ff      <= '0;
         fix_front_ff <= 1'b0;
         fix_rear_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         fix_front_ff <= fix_front_in;
         fix_rear_ff  <= fix_rear_in;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

FILE: design/circular_deque.sv
`default_nettype none
// ---------------------------------------------------------------------------
// circular_deque: double-ended queue of signed words in a ring store
// Push and pop at either end; one result per item with the popped word,
// the front and rear words, the occupancy, flags and a status code.
// ---------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   kind, value
//   rsp      out        rsp_valid/rsp_stall   popped, front_word, rear_word,
//                                             occupancy, empty_res, full_res,
//                                             status
//
// An item passes through IDLE and EXEC: in IDLE the accept updates the pointers
// and writes or reads the ring store, and in EXEC the registered store read
// refreshes the cached front or rear word and the result is loaded.
// The result register lets a new item in while the last result waits.
// A stalled result holds the control in EXEC until it leaves.
// Reset is synchronous and empties the queue; the store itself is not cleared.
// ---------------------------------------------------------------------------
module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = CDQ_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_kind,
   input  wire logic signed [CDQ_WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [CDQ_WORD_W-1:0]      rsp_popped,
   output logic signed [CDQ_WORD_W-1:0]      rsp_front_word,
   output logic signed [CDQ_WORD_W-1:0]      rsp_rear_word,
   output logic [CDQ_OCC_W-1:0]              rsp_occupancy,
   output logic                              rsp_empty_res,
   output logic                              rsp_full_res,
   output logic [1:0]                        rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                         out_free;
   logic                         done;
   cdq_result_type               result;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic signed [CDQ_WORD_W-1:0] wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic signed [CDQ_WORD_W-1:0] rd_data;

   logic           rsp_valid_ff, rsp_valid_in;
   cdq_result_type result_ff;

   cdq_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_value (req_value),
      .req_stall (req_stall),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_popped     = result_ff.popped;
   assign rsp_front_word = result_ff.front_word;
   assign rsp_rear_word  = result_ff.rear_word;
   assign rsp_occupancy  = result_ff.occupancy;
   assign rsp_empty_res  = result_ff.empty_res;
   assign rsp_full_res   = result_ff.full_res;
   assign rsp_status     = result_ff.status;

endmodule
`default_nettype wire
